// File: sv/fifo_evict_key_value_store_assert.svh
`ifndef FIFO_EVICT_KEY_VALUE_STORE_ASSERT_SVH
`define FIFO_EVICT_KEY_VALUE_STORE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define FKV_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FKV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/fkv_pkg.sv
package fkv_pkg;

  localparam int DEPTH   = 128;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CAP_W   = 8;
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(100);

  localparam logic KIND_PUT = 1'b0;
  localparam logic KIND_GET = 1'b1;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [VAL_W-1:0]        val_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_UPD  = 2'b10
  } state_e;

  // control broadcast to every cell
  typedef struct packed {
    logic cmp;
    logic upd;
    logic shift;
    logic append;
    logic hit_wr;
    idx_t tgt;
    cnt_t cnt;
    key_t key;
    val_t value;
  } cell_ctrl_t;

endpackage

// File: sv/fkv_in_if.sv
interface fkv_in_if;
  import fkv_pkg::*;
  logic valid;
  logic ready;
  logic kind;
  key_t key;
  val_t value;
  modport source(output valid, kind, key, value, input ready);
  modport sink(input valid, kind, key, value, output ready);
endinterface

// File: sv/fkv_out_if.sv
interface fkv_out_if;
  import fkv_pkg::*;
  logic valid;
  logic ready;
  logic found;
  val_t read_value;
  logic released;
  val_t released_value;
  modport source(output valid, found, read_value, released, released_value, input ready);
  modport sink(input valid, found, read_value, released, released_value, output ready);
endinterface

// File: sv/fkv_cfg_if.sv
interface fkv_cfg_if;
  import fkv_pkg::*;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// File: sv/fkv_cell.sv
module fkv_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fkv_pkg::idx_t       idx_i,
  input  fkv_pkg::cell_ctrl_t ctrl_i,
  input  fkv_pkg::key_t       nbr_key_i,
  input  fkv_pkg::val_t       nbr_value_i,
  output fkv_pkg::key_t       key_o,
  output fkv_pkg::val_t       value_o,
  output logic                hit_o,
  output fkv_pkg::val_t       match_value_o
);
  import fkv_pkg::*;

  key_t key_q;
  val_t value_q;
  logic hit_q;
  logic live;
  logic is_tgt;

  assign live   = cnt_t'(idx_i) < ctrl_i.cnt;
  assign is_tgt = idx_i == ctrl_i.tgt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (ctrl_i.cmp) begin
      hit_q <= live && (key_q == ctrl_i.key);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.upd) begin
      if (ctrl_i.shift) begin
        if (is_tgt) begin
          key_q   <= ctrl_i.key;
          value_q <= ctrl_i.value;
        end else begin
          key_q   <= nbr_key_i;
          value_q <= nbr_value_i;
        end
      end else if (ctrl_i.append && is_tgt) begin
        key_q   <= ctrl_i.key;
        value_q <= ctrl_i.value;
      end else if (ctrl_i.hit_wr && hit_q) begin
        value_q <= ctrl_i.value;
      end
    end
  end

  assign key_o         = key_q;
  assign value_o       = value_q;
  assign hit_o         = hit_q;
  assign match_value_o = hit_q ? value_q : '0;

endmodule

// File: sv/fifo_evict_key_value_store.sv
// channel | dir | modport | payload
// in_i    | in  | sink    | kind, key, value
// out_o   | out | source  | found, read_value, released, released_value
// cfg_i   | in  | sink    | data (capacity)
//
// Items do not overlap: the accept edge runs the key compare in every cell,
// the update edge updates the cell row and loads the result register.
// Eviction shifts the whole row one cell toward the oldest end in that edge.
// A full result register that is not taken holds the update cycle.
// Reset: store empty, capacity 100; no clearing pass.
module fifo_evict_key_value_store (
  input  logic clk_i,
  input  logic rst_ni,
  fkv_in_if.sink    in_i,
  fkv_out_if.source out_o,
  fkv_cfg_if.sink   cfg_i
);
  import fkv_pkg::*;
  `include "fifo_evict_key_value_store_assert.svh"

  state_e           state_q, state_d;
  logic [CAP_W-1:0] cap_q;
  cnt_t             cnt_q;
  logic             kind_q;
  key_t             key_q;
  val_t             value_q;

  logic             out_valid_q;
  logic             found_q, released_q;
  val_t             read_value_q, released_value_q;

  cell_ctrl_t       ctrl;
  key_t             cell_key   [DEPTH];
  val_t             cell_value [DEPTH];
  val_t             cell_match [DEPTH];
  logic [DEPTH-1:0] hit_vec;

  logic             accept;
  logic             upd_fire;
  logic             hit_any;
  val_t             hit_value;
  logic [CMP_W-1:0] eff_cap;
  logic             evict;
  val_t             rel_value;

  assign in_i.ready  = state_q == ST_IDLE;
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && in_i.ready;
  assign upd_fire    = (state_q == ST_UPD) && (!out_valid_q || out_o.ready);

  always_comb begin
    hit_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_value = hit_value | cell_match[i];
    end
  end
  assign hit_any = |hit_vec;

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(cap_q) > CMP_W'(DEPTH)) begin
      eff_cap = CMP_W'(DEPTH);
    end else begin
      eff_cap = CMP_W'(cap_q);
    end
  end

  assign evict     = (kind_q == KIND_PUT) && !hit_any && (CMP_W'(cnt_q) >= eff_cap)
                     && (cnt_q != '0);
  assign rel_value = hit_any ? hit_value : (evict ? cell_value[0] : '0);

  always_comb begin
    ctrl        = '0;
    ctrl.cmp    = accept;
    ctrl.upd    = upd_fire;
    ctrl.cnt    = cnt_q;
    ctrl.key    = accept ? in_i.key : key_q;
    ctrl.value  = value_q;
    ctrl.shift  = evict;
    ctrl.append = (kind_q == KIND_PUT) && !hit_any;
    ctrl.hit_wr = (kind_q == KIND_PUT) && hit_any;
    ctrl.tgt    = evict ? idx_t'(cnt_q - cnt_t'(1)) : idx_t'(cnt_q);
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    key_t nbr_key;
    val_t nbr_value;
    if (i == DEPTH - 1) begin : g_last
      assign nbr_key   = '0;
      assign nbr_value = '0;
    end else begin : g_mid
      assign nbr_key   = cell_key[i+1];
      assign nbr_value = cell_value[i+1];
    end
    fkv_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .idx_i         (idx_t'(i)),
      .ctrl_i        (ctrl),
      .nbr_key_i     (nbr_key),
      .nbr_value_i   (nbr_value),
      .key_o         (cell_key[i]),
      .value_o       (cell_value[i]),
      .hit_o         (hit_vec[i]),
      .match_value_o (cell_match[i])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (upd_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CAP_RESET;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        cap_q <= cfg_i.data;
      end
      if (upd_fire && (kind_q == KIND_PUT) && !hit_any && !evict) begin
        cnt_q <= cnt_q + cnt_t'(1);
      end
      if (upd_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= in_i.kind;
      key_q   <= in_i.key;
      value_q <= in_i.value;
    end
    if (upd_fire) begin
      found_q          <= hit_any;
      read_value_q     <= (kind_q == KIND_GET) ? hit_value : '0;
      released_q       <= (kind_q == KIND_PUT) && (rel_value != '0);
      released_value_q <= (kind_q == KIND_PUT) ? rel_value : '0;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.found          = found_q;
  assign out_o.read_value     = read_value_q;
  assign out_o.released       = released_q;
  assign out_o.released_value = released_value_q;

  `FKV_ASSERT(a_cnt_bound, 1'b1, cnt_q <= cnt_t'(DEPTH), "entry count above depth")
  `FKV_ASSERT(a_one_hit, state_q == ST_UPD, $onehot0(hit_vec), "key held in two cells")
  `FKV_ASSERT_NEXT(a_acc_upd, accept, state_q == ST_UPD, "accepted item skipped update")
  `FKV_ASSERT_NEXT(a_append_cnt, upd_fire && ctrl.append && !evict,
                   cnt_q == $past(cnt_q) + cnt_t'(1), "append did not grow count")
  `FKV_ASSERT(a_rsp_src, $rose(out_valid_q), $past(state_q == ST_UPD),
              "result without update cycle")

endmodule

// File: verif/tb_fifo_evict_key_value_store.sv
module tb_fifo_evict_key_value_store;
  timeunit 1ns;
  timeprecision 1ps;

  import fkv_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 3000;
  localparam int NUM_ROWS    = 22;

  typedef struct packed {
    logic found;
    val_t read_value;
    logic released;
    val_t released_value;
  } outcome_t;

  typedef enum logic [1:0] {
    ROW_PUT,
    ROW_GET,
    ROW_CFG
  } row_op_e;

  typedef struct packed {
    row_op_e  op;
    key_t     key;
    val_t     value;
    logic     typed;
    outcome_t want;
  } drill_row_t;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE
  } rx_mode_e;

  localparam outcome_t MISS = '0;

  logic clk_i;
  logic rst_ni;

  fkv_in_if  in_if ();
  fkv_out_if out_if ();
  fkv_cfg_if cfg_if ();

  fifo_evict_key_value_store uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  key_t shadow_keys [DEPTH];
  val_t shadow_vals [DEPTH];
  int   shadow_head;
  int   shadow_count;
  int   shadow_capacity;

  outcome_t   access_outcomes [$];
  key_t       key_pool [256];
  drill_row_t drill_rows [NUM_ROWS];

  int error_count;
  int burst_left;
  int idle_cycles;
  bit start_hold;

  always #(HALF_PERIOD) clk_i = ~clk_i;

  function automatic outcome_t store_access(input logic kind, input key_t key,
                                            input val_t value);
    outcome_t o;
    int       limit;
    int       slot;
    int       s;
    bit       hit;
    o = '0;
    hit = 1'b0;
    slot = 0;
    if (shadow_capacity == 0) limit = 1;
    else if (shadow_capacity > DEPTH) limit = DEPTH;
    else limit = shadow_capacity;
    for (int i = 0; i < shadow_count; i++) begin
      s = (shadow_head + i) % DEPTH;
      if (!hit && shadow_keys[s] == key) begin
        hit = 1'b1;
        slot = s;
      end
    end
    if (kind == KIND_GET) begin
      if (hit) begin
        o.found = 1'b1;
        o.read_value = shadow_vals[slot];
      end
    end else if (hit) begin
      o.found = 1'b1;
      if (shadow_vals[slot] != '0) begin
        o.released = 1'b1;
        o.released_value = shadow_vals[slot];
      end
      shadow_vals[slot] = value;
    end else begin
      if (shadow_count >= limit && shadow_count > 0) begin
        if (shadow_vals[shadow_head] != '0) begin
          o.released = 1'b1;
          o.released_value = shadow_vals[shadow_head];
        end
        shadow_head = (shadow_head + 1) % DEPTH;
        shadow_count--;
      end
      slot = (shadow_head + shadow_count) % DEPTH;
      shadow_keys[slot] = key;
      shadow_vals[slot] = value;
      shadow_count++;
    end
    return o;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    $display("mismatch %s: expected %h got %h at %0t", what, want, got, $time);
    error_count++;
  endtask

  task automatic offer_access(input logic kind, input key_t key, input val_t value,
                              input logic typed, input outcome_t typed_want);
    outcome_t want;
    int       gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.kind  <= kind;
    in_if.key   <= key;
    in_if.value <= value;
    do @(posedge clk_i); while (!in_if.ready);
    want = store_access(kind, key, value);
    if (typed) want = typed_want;
    access_outcomes.push_back(want);
  endtask

  task automatic wait_drained();
    while (access_outcomes.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    in_if.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (access_outcomes.size() != 0);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= cap;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    shadow_capacity = cap;
  endtask

  task automatic refill_pool();
    foreach (key_pool[i]) key_pool[i] = key_t'($urandom);
  endtask

  task automatic run_random(input int count, input int pool_size);
    logic kind;
    key_t key;
    val_t value;
    repeat (count) begin
      kind  = ($urandom_range(0, 9) < 6) ? KIND_PUT : KIND_GET;
      key   = ($urandom_range(0, 9) == 0) ? key_t'($urandom)
                                          : key_pool[$urandom_range(0, pool_size - 1)];
      value = ($urandom_range(0, 6) == 0) ? val_t'(0) : val_t'($urandom);
      offer_access(kind, key, value, 1'b0, MISS);
    end
  endtask

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (access_outcomes.size() == 0) begin
        flag_mismatch("result with nothing pending", '0, out_if.read_value);
      end else begin
        want = access_outcomes.pop_front();
        if (out_if.found !== want.found)
          flag_mismatch("found", 32'(want.found), 32'(out_if.found));
        if (out_if.read_value !== want.read_value)
          flag_mismatch("read_value", want.read_value, out_if.read_value);
        if (out_if.released !== want.released)
          flag_mismatch("released", 32'(want.released), 32'(out_if.released));
        if (out_if.released_value !== want.released_value)
          flag_mismatch("released_value", want.released_value, out_if.released_value);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL fifo_evict_key_value_store");
        $finish;
      end
    end
  end

  initial begin : receiver
    int       seg_left;
    int       hold_left;
    rx_mode_e rx_mode;
    out_if.ready = 1'b0;
    seg_left = 0;
    hold_left = 0;
    rx_mode = RX_OPEN;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && start_hold) begin
        start_hold = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          rx_mode = rx_mode_e'($urandom_range(0, 2));
          seg_left = $urandom_range(5, 60);
        end
        seg_left--;
        case (rx_mode)
          RX_OPEN: out_if.ready <= 1'b1;
          RX_COIN: out_if.ready <= 1'($urandom_range(0, 1));
          default: out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    int cap;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.kind = KIND_PUT;
    in_if.key = '0;
    in_if.value = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    error_count = 0;
    burst_left = 0;
    idle_cycles = 0;
    start_hold = 1'b0;
    shadow_head = 0;
    shadow_count = 0;
    shadow_capacity = CAP_RESET;
    foreach (shadow_keys[i]) begin
      shadow_keys[i] = '0;
      shadow_vals[i] = '0;
    end

    drill_rows = '{
      '{ROW_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, MISS},
      '{ROW_PUT, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, MISS},
      '{ROW_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0}},
      '{ROW_PUT, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, MISS},
      '{ROW_PUT, 32'h7FFF_FFFF, 32'h1234_5678, 1'b1, '{1'b1, 32'h0, 1'b0, 32'h0}},
      '{ROW_PUT, 32'h8000_0000, 32'h0000_0001, 1'b1, '{1'b1, 32'h0, 1'b1, 32'hFFFF_FFFF}},
      '{ROW_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, '{1'b1, 32'h1234_5678, 1'b0, 32'h0}},
      '{ROW_PUT, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 1'b0, MISS},
      '{ROW_PUT, 32'h0000_0000, 32'h5A5A_5A5A, 1'b0, MISS},
      '{ROW_GET, 32'hFFFF_FFFF, 32'hDEAD_BEEF, 1'b0, MISS},
      '{ROW_CFG, 32'h0000_0000, 32'h0000_0002, 1'b0, MISS},
      '{ROW_PUT, 32'h1111_1111, 32'h0000_0007, 1'b0, MISS},
      '{ROW_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, MISS},
      '{ROW_PUT, 32'h2222_2222, 32'h0000_0008, 1'b0, MISS},
      '{ROW_CFG, 32'h0000_0000, 32'h0000_0000, 1'b0, MISS},
      '{ROW_PUT, 32'h3333_3333, 32'h0000_0000, 1'b0, MISS},
      '{ROW_GET, 32'h2222_2222, 32'h0000_0000, 1'b0, MISS},
      '{ROW_CFG, 32'h0000_0000, 32'h0000_00FF, 1'b0, MISS},
      '{ROW_PUT, 32'h4444_4444, 32'h0000_0009, 1'b0, MISS},
      '{ROW_GET, 32'h3333_3333, 32'h0000_0000, 1'b0, MISS},
      '{ROW_PUT, 32'h3333_3333, 32'h0000_0003, 1'b0, MISS},
      '{ROW_CFG, 32'h0000_0000, 32'h0000_0064, 1'b0, MISS}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (drill_rows[i]) begin
      case (drill_rows[i].op)
        ROW_CFG: write_capacity(drill_rows[i].value[CAP_W-1:0]);
        ROW_PUT: offer_access(KIND_PUT, drill_rows[i].key, drill_rows[i].value,
                              drill_rows[i].typed, drill_rows[i].want);
        default: offer_access(KIND_GET, drill_rows[i].key, drill_rows[i].value,
                              drill_rows[i].typed, drill_rows[i].want);
      endcase
    end

    refill_pool();
    write_capacity(8'd1);
    run_random(80, 4);

    // fill to full depth and wrap; output held off so the input backs up
    refill_pool();
    write_capacity(8'd128);
    start_hold = 1'b1;
    run_random(250, 160);

    // lowered below the live count, old keys still in the pool
    write_capacity(8'd3);
    run_random(100, 160);

    refill_pool();
    write_capacity(8'd0);
    run_random(60, 4);

    refill_pool();
    write_capacity(8'd255);
    run_random(100, 200);

    refill_pool();
    write_capacity(8'd2);
    run_random(60, 5);

    refill_pool();
    cap = $urandom_range(1, 127);
    write_capacity(CAP_W'(cap));
    run_random(150, cap + cap / 2 + 2);

    in_if.valid <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk_i);
    if (error_count == 0 && access_outcomes.size() == 0) begin
      $display("PASS fifo_evict_key_value_store");
    end else begin
      $display("FAIL fifo_evict_key_value_store");
    end
    $finish;
  end

endmodule
